FILE: rtl/core/sere_pkg.sv
package sere_pkg;

  localparam int unsigned InWidth   = 64;
  localparam int unsigned OutWidth  = 80;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned CfgDataW  = 16;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgScreenFlip = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgVisWidth   = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgVisHeight  = 2'd2;
  localparam logic [CfgIdxW-1:0] CfgBankSelect = 2'd3;

  localparam logic [10:0] VisWidthReset  = 11'd320;
  localparam logic [10:0] VisHeightReset = 11'd240;

  localparam int unsigned HideBit = 10;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;   // latch and decode the incoming entry
    logic step;   // emit the current row into the output register
  } sere_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic hidden;    // incoming entry has its hide bit set
    logic last;      // current row is the final one
    logic out_free;  // output register can take a word this cycle
  } sere_sts_t;

  function automatic logic [7:0] prio_mask(input logic [1:0] prio);
    logic [7:0] m;
    case (prio)
      2'd0:    m = 8'h00;
      2'd1:    m = 8'hf0;
      2'd2:    m = 8'hf0 | 8'hcc;
      2'd3:    m = 8'hf0 | 8'hcc | 8'haa;
      default: m = 8'h00;
    endcase
    return m;
  endfunction

endpackage

FILE: rtl/core/sere_ctrl.sv
module sere_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  sere_pkg::sere_sts_t sts_i,
  output sere_pkg::sere_cmd_t cmd_o
);

  localparam logic StIdle = 1'b0;
  localparam logic StRun  = 1'b1;

  logic state_q, state_d;

  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i && !sts_i.hidden) begin
          cmd_o.load = 1'b1;
          state_d    = StRun;
        end
      end
      StRun: begin
        if (sts_i.out_free) begin
          cmd_o.step = 1'b1;
          if (sts_i.last) begin
            state_d = StIdle;
          end
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

FILE: rtl/core/sere_dp.sv
module sere_dp (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [sere_pkg::CfgIdxW-1:0]      cfg_index_i,
  input  logic [sere_pkg::CfgDataW-1:0]     cfg_wdata_i,
  input  logic [sere_pkg::InWidth-1:0]      in_data_i,
  input  logic                              out_ready_i,
  output logic                              out_valid_o,
  output logic [sere_pkg::OutWidth-1:0]     out_data_o,
  output logic                              out_last_o,
  input  sere_pkg::sere_cmd_t               cmd_i,
  output sere_pkg::sere_sts_t               sts_o
);

  // configuration
  logic        scr_flip_q;
  logic [10:0] vis_w_q, vis_h_q;
  logic [15:0] bank_sel_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scr_flip_q <= 1'b0;
      vis_w_q    <= sere_pkg::VisWidthReset;
      vis_h_q    <= sere_pkg::VisHeightReset;
      bank_sel_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        sere_pkg::CfgScreenFlip: scr_flip_q <= cfg_wdata_i[0];
        sere_pkg::CfgVisWidth:   vis_w_q    <= cfg_wdata_i[10:0];
        sere_pkg::CfgVisHeight:  vis_h_q    <= cfg_wdata_i[10:0];
        sere_pkg::CfgBankSelect: bank_sel_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // entry decode
  logic [15:0] xw, yw, aw, cw;
  logic [3:0]  bank;
  logic [4:0]  xnum, ynum;
  logic [11:0] x_s, y_s, sx_d, sy_d;
  logic        fx_d, fy_d;
  logic [7:0]  xzoom_d, yzoom_d;

  always_comb begin
    xw      = in_data_i[15:0];
    yw      = in_data_i[31:16];
    aw      = in_data_i[47:32];
    cw      = in_data_i[63:48];
    bank    = bank_sel_q[{cw[15:14], 2'b00} +: 4];
    xnum    = {1'b0, xw[15:12]} + 5'd1;
    ynum    = {1'b0, yw[15:12]} + 5'd1;
    x_s     = {{2{xw[9]}}, xw[9:0]};
    y_s     = {{2{yw[9]}}, yw[9:0]};
    xzoom_d = 8'd128 - {2'b00, aw[15:12], 2'b00};
    yzoom_d = 8'd128 - {2'b00, aw[11:8], 2'b00};
    fx_d    = xw[11] ^ scr_flip_q;
    fy_d    = yw[11] ^ scr_flip_q;
    // mirror about the visible area; only the low 12 bits are kept
    if (scr_flip_q) begin
      sx_d = {1'b0, vis_w_q} - x_s - {3'b000, xnum, 4'b0000};
      sy_d = {1'b0, vis_h_q} - y_s - {3'b000, ynum, 4'b0000};
    end else begin
      sx_d = x_s;
      sy_d = y_s;
    end
  end

  // latched entry
  logic [17:0] code_q;
  logic [5:0]  color_q;
  logic        fx_q, fy_q, zoomed_q;
  logic [11:0] sx_q, sy_q;
  logic [4:0]  xnum_q;
  logic [3:0]  ylast_q, row_q;
  logic [7:0]  xzoom_q, yzoom_q, pmask_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      code_q   <= {bank, cw[13:0]};
      color_q  <= aw[5:0];
      fx_q     <= fx_d;
      fy_q     <= fy_d;
      sx_q     <= sx_d;
      sy_q     <= sy_d;
      xnum_q   <= xnum;
      ylast_q  <= yw[15:12];
      xzoom_q  <= xzoom_d;
      yzoom_q  <= yzoom_d;
      pmask_q  <= sere_pkg::prio_mask(aw[7:6]);
      zoomed_q <= (aw[15:8] != 8'h00);
      row_q    <= '0;
    end else if (cmd_i.step) begin
      // advance the row code by one row of tiles
      code_q <= code_q + {13'd0, xnum_q};
      row_q  <= row_q + 4'd1;
    end
  end

  // row position, bottom to top when flipped
  logic [3:0]  pos;
  logic [11:0] prod;
  logic [11:0] row_y;

  always_comb begin
    pos   = fy_q ? (ylast_q - row_q) : row_q;
    prod  = {8'd0, pos} * {4'd0, yzoom_q};
    row_y = sy_q + {3'b000, prod[11:3]};
  end

  // output register
  logic                            out_valid_q;
  logic [sere_pkg::OutWidth-1:0]   out_data_q;
  logic                            out_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.step) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.step) begin
      out_data_q <= {zoomed_q, pmask_q, yzoom_q, xzoom_q, xnum_q, row_y, sx_q,
                     fy_q, fx_q, color_q, code_q};
      out_last_q <= (row_q == ylast_q);
    end
  end

  assign out_valid_o     = out_valid_q;
  assign out_data_o      = out_data_q;
  assign out_last_o      = out_last_q;
  assign sts_o.hidden    = in_data_i[sere_pkg::HideBit];
  assign sts_o.last      = (row_q == ylast_q);
  assign sts_o.out_free  = !out_valid_q || out_ready_i;

endmodule

FILE: rtl/core/sprite_entry_row_expander.sv
// Sprite list entry row expander. Each input word is one sprite list entry
// (x_word, y_word, attr_word, code_word from the lowest bits up); it yields
// one row descriptor per tile row in draw order, with tlast on the final row,
// and a hidden entry yields nothing. An entry is taken while the block is
// idle, then one row is generated per cycle into the output register whenever
// that register is free, so back-pressure on the output stalls the row steps.
// A visible entry of 1 to 16 tile rows holds the block until its final row
// is stepped out. The next entry is accepted while the last row still
// waits in the output register. Configuration writes are taken at any time
// but belong to periods with no entry in flight.
module sprite_entry_row_expander (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [sere_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  logic [sere_pkg::CfgDataW-1:0]    cfg_wdata_i,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // x_word[15:0], y_word[31:16], attr_word[47:32], code_word[63:48]
  input  logic [sere_pkg::InWidth-1:0]     s_axis_tdata,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // row_tile_code[17:0], color[23:18], flip_x[24], flip_y[25], x_origin[37:26],
  // row_y[49:38], tiles_in_row[54:50], x_zoom[62:55], y_zoom[70:63],
  // priority_mask[78:71], zoomed[79]
  output logic [sere_pkg::OutWidth-1:0]    m_axis_tdata,
  output logic                             m_axis_tlast
);

  sere_pkg::sere_cmd_t cmd;
  sere_pkg::sere_sts_t sts;

  sere_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  sere_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_data_i   (s_axis_tdata),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_data_o  (m_axis_tdata),
    .out_last_o  (m_axis_tlast),
    .cmd_i       (cmd),
    .sts_o       (sts)
  );

endmodule

FILE: rtl/core/sere_checker.sv
module sere_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          s_axis_tvalid,
  input logic                          s_axis_tready,
  input logic [sere_pkg::InWidth-1:0]  s_axis_tdata,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [sere_pkg::OutWidth-1:0] m_axis_tdata,
  input logic                          m_axis_tlast
);

  // a visible entry blocks the input while its rows go out
  a_busy_after_visible: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && !s_axis_tdata[sere_pkg::HideBit]
    |=> !s_axis_tready)
    else $error("input ready after visible entry");

  // a hidden entry leaves the input open
  a_open_after_hidden: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && s_axis_tdata[sere_pkg::HideBit]
    |=> s_axis_tready)
    else $error("input closed after hidden entry");

  // input reopens only once the final row has been produced
  a_reopen_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(s_axis_tready) |-> m_axis_tvalid && m_axis_tlast)
    else $error("input reopened before final row");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready
    |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("stalled output word changed");

endmodule

bind sprite_entry_row_expander sere_checker u_sere_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tdata  (s_axis_tdata),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);

FILE: verif/sere_row_checker.sv
module sere_row_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [sere_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [sere_pkg::CfgDataW-1:0] cfg_wdata_i,
  input  logic                          s_tvalid_i,
  input  logic                          s_tready_i,
  input  logic [sere_pkg::InWidth-1:0]  s_tdata_i,
  input  logic                          m_tvalid_i,
  input  logic                          m_tready_i,
  input  logic [sere_pkg::OutWidth-1:0] m_tdata_i,
  input  logic                          m_tlast_i,
  output int                            fail_count_o,
  output int                            pending_o
);

  typedef struct packed {
    logic [17:0] tile_code;
    logic [5:0]  color;
    logic        flip_x;
    logic        flip_y;
    logic [11:0] x_origin;
    logic [11:0] row_y;
    logic [4:0]  tiles_in_row;
    logic [7:0]  x_zoom;
    logic [7:0]  y_zoom;
    logic [7:0]  layers;
    logic        zoomed;
    logic        last_row;
  } row_desc_t;

  logic        mirror_on;
  logic [10:0] vis_width;
  logic [10:0] vis_height;
  logic [15:0] bank_word;

  row_desc_t expected_rows[$];
  int        mismatches = 0;
  int        rows_seen = 0;

  assign fail_count_o = mismatches;

  function automatic void note_mismatch(input string what, input logic [31:0] want,
                                        input logic [31:0] got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%0t: row word %0d: %s expected %0h got %0h", $time, rows_seen, what,
               want, got);
    end
  endfunction

  function automatic logic [7:0] layer_mask(input logic [1:0] prio);
    logic [7:0] m;
    case (prio)
      2'd0:    m = 8'h00;
      2'd1:    m = 8'hf0;
      2'd2:    m = 8'hfc;
      default: m = 8'hfe;
    endcase
    return m;
  endfunction

  // Queue one row descriptor per tile row, in draw order.
  function automatic void expand_entry(input logic [63:0] entry);
    logic [15:0] xw, yw, aw, cw;
    logic [3:0]  bank;
    logic        fx, fy;
    int          base, cols, rows, zx, zy, sx, sy, pos, ry, code, r;
    row_desc_t   row;
    xw = entry[15:0];
    yw = entry[31:16];
    aw = entry[47:32];
    cw = entry[63:48];
    if (xw[sere_pkg::HideBit]) return;
    bank = bank_word[{cw[15:14], 2'b00} +: 4];
    base = int'(cw[13:0]) + int'(bank) * 'h4000;
    cols = int'(xw[15:12]) + 1;
    rows = int'(yw[15:12]) + 1;
    zx = 128 - 4 * int'(aw[15:12]);
    zy = 128 - 4 * int'(aw[11:8]);
    fx = xw[11];
    fy = yw[11];
    sx = int'($signed(xw[9:0]));
    sy = int'($signed(yw[9:0]));
    if (mirror_on) begin
      fx = ~fx;
      fy = ~fy;
      sx = int'(vis_width) - sx - cols * 16;
      sy = int'(vis_height) - sy - rows * 16;
    end
    for (r = 0; r < rows; r++) begin
      pos = fy ? rows - 1 - r : r;
      ry = sy + (pos * zy) / 8;
      code = base + r * cols;
      row.tile_code    = code[17:0];
      row.color        = aw[5:0];
      row.flip_x       = fx;
      row.flip_y       = fy;
      row.x_origin     = sx[11:0];
      row.row_y        = ry[11:0];
      row.tiles_in_row = cols[4:0];
      row.x_zoom       = zx[7:0];
      row.y_zoom       = zy[7:0];
      row.layers       = layer_mask(aw[7:6]);
      row.zoomed       = (zx != 128) || (zy != 128);
      row.last_row     = (r == rows - 1);
      expected_rows.push_back(row);
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    row_desc_t got, want;
    if (!rst_ni) begin
      mirror_on   = 1'b0;
      vis_width   = sere_pkg::VisWidthReset;
      vis_height  = sere_pkg::VisHeightReset;
      bank_word   = '0;
      expected_rows.delete();
      pending_o <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          sere_pkg::CfgScreenFlip: mirror_on   = cfg_wdata_i[0];
          sere_pkg::CfgVisWidth:   vis_width   = cfg_wdata_i[10:0];
          sere_pkg::CfgVisHeight:  vis_height  = cfg_wdata_i[10:0];
          default:                 bank_word   = cfg_wdata_i;
        endcase
      end
      // Retire the output word before queuing rows of a new entry.
      if (m_tvalid_i && m_tready_i) begin
        got.tile_code    = m_tdata_i[17:0];
        got.color        = m_tdata_i[23:18];
        got.flip_x       = m_tdata_i[24];
        got.flip_y       = m_tdata_i[25];
        got.x_origin     = m_tdata_i[37:26];
        got.row_y        = m_tdata_i[49:38];
        got.tiles_in_row = m_tdata_i[54:50];
        got.x_zoom       = m_tdata_i[62:55];
        got.y_zoom       = m_tdata_i[70:63];
        got.layers       = m_tdata_i[78:71];
        got.zoomed       = m_tdata_i[79];
        got.last_row     = m_tlast_i;
        if (expected_rows.size() == 0) begin
          note_mismatch("unexpected row, tile code", '0, 32'(got.tile_code));
        end else begin
          want = expected_rows.pop_front();
          if (got.tile_code !== want.tile_code)
            note_mismatch("row_tile_code", 32'(want.tile_code), 32'(got.tile_code));
          if (got.color !== want.color)
            note_mismatch("color", 32'(want.color), 32'(got.color));
          if (got.flip_x !== want.flip_x)
            note_mismatch("flip_x", 32'(want.flip_x), 32'(got.flip_x));
          if (got.flip_y !== want.flip_y)
            note_mismatch("flip_y", 32'(want.flip_y), 32'(got.flip_y));
          if (got.x_origin !== want.x_origin)
            note_mismatch("x_origin", 32'(want.x_origin), 32'(got.x_origin));
          if (got.row_y !== want.row_y)
            note_mismatch("row_y", 32'(want.row_y), 32'(got.row_y));
          if (got.tiles_in_row !== want.tiles_in_row)
            note_mismatch("tiles_in_row", 32'(want.tiles_in_row), 32'(got.tiles_in_row));
          if (got.x_zoom !== want.x_zoom)
            note_mismatch("x_zoom", 32'(want.x_zoom), 32'(got.x_zoom));
          if (got.y_zoom !== want.y_zoom)
            note_mismatch("y_zoom", 32'(want.y_zoom), 32'(got.y_zoom));
          if (got.layers !== want.layers)
            note_mismatch("priority_mask", 32'(want.layers), 32'(got.layers));
          if (got.zoomed !== want.zoomed)
            note_mismatch("zoomed", 32'(want.zoomed), 32'(got.zoomed));
          if (got.last_row !== want.last_row)
            note_mismatch("last_row", 32'(want.last_row), 32'(got.last_row));
        end
        rows_seen++;
      end
      if (s_tvalid_i && s_tready_i) expand_entry(s_tdata_i);
      pending_o <= expected_rows.size();
    end
  end

endmodule

FILE: verif/testbench.sv
module testbench;

  localparam int RxFree     = 0;
  localparam int RxLight    = 1;
  localparam int RxHeavy    = 2;
  localparam int RxPeriodic = 3;

  // Enough for the slowest entry to drain once the queue looks empty.
  localparam int SettleCycles = 20;

  logic                          clk_i;
  logic                          rst_ni = 1'b0;
  logic                          cfg_we = 1'b0;
  logic [sere_pkg::CfgIdxW-1:0]  cfg_index = sere_pkg::CfgScreenFlip;
  logic [sere_pkg::CfgDataW-1:0] cfg_wdata = '0;
  logic                          s_tvalid = 1'b0;
  logic                          s_tready;
  logic [sere_pkg::InWidth-1:0]  s_tdata = '0;
  logic                          m_tvalid;
  logic                          m_tready = 1'b0;
  logic [sere_pkg::OutWidth-1:0] m_tdata;
  logic                          m_tlast;

  int fail_count;
  int rows_pending;
  int burst_left = 0;
  int stall_mode = RxFree;
  int stall_span = 0;
  int stall_tick = 0;

  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  sprite_entry_row_expander i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we),
    .cfg_index_i   (cfg_index),
    .cfg_wdata_i   (cfg_wdata),
    .s_axis_tvalid (s_tvalid),
    .s_axis_tready (s_tready),
    .s_axis_tdata  (s_tdata),
    .m_axis_tvalid (m_tvalid),
    .m_axis_tready (m_tready),
    .m_axis_tdata  (m_tdata),
    .m_axis_tlast  (m_tlast)
  );

  sere_row_checker i_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we),
    .cfg_index_i  (cfg_index),
    .cfg_wdata_i  (cfg_wdata),
    .s_tvalid_i   (s_tvalid),
    .s_tready_i   (s_tready),
    .s_tdata_i    (s_tdata),
    .m_tvalid_i   (m_tvalid),
    .m_tready_i   (m_tready),
    .m_tdata_i    (m_tdata),
    .m_tlast_i    (m_tlast),
    .fail_count_o (fail_count),
    .pending_o    (rows_pending)
  );

  // Receiver: pick a new stall style each time the current span runs out.
  always @(posedge clk_i) begin
    if (stall_span == 0) begin
      stall_mode <= $urandom_range(RxFree, RxPeriodic);
      stall_span <= $urandom_range(16, 96);
    end else begin
      stall_span <= stall_span - 1;
    end
    stall_tick <= stall_tick + 1;
    case (stall_mode)
      RxFree:  m_tready <= 1'b1;
      RxLight: m_tready <= ($urandom_range(0, 3) != 0);
      RxHeavy: m_tready <= ($urandom_range(0, 4) == 0);
      default: m_tready <= (stall_tick % 7) < 3;
    endcase
  end

  task automatic send_entry(input logic [63:0] entry);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(1, 6);
      burst_left = ($urandom_range(0, 4) == 0) ? 40 : $urandom_range(1, 8);
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tdata  <= entry;
    do @(posedge clk_i); while (!s_tready);
  endtask

  // Hold the input until every queued row is out, then let the block settle.
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    do @(posedge clk_i); while (rows_pending != 0);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // Unused upper data bits carry noise; the block must drop them.
  task automatic write_config(input logic flip, input logic [10:0] width,
                              input logic [10:0] height, input logic [15:0] banks);
    logic [15:0] fill;
    fill = 16'($urandom);
    cfg_we    <= 1'b1;
    cfg_index <= sere_pkg::CfgScreenFlip;
    cfg_wdata <= {fill[15:1], flip};
    @(posedge clk_i);
    cfg_index <= sere_pkg::CfgVisWidth;
    cfg_wdata <= {fill[4:0], width};
    @(posedge clk_i);
    cfg_index <= sere_pkg::CfgVisHeight;
    cfg_wdata <= {fill[9:5], height};
    @(posedge clk_i);
    cfg_index <= sere_pkg::CfgBankSelect;
    cfg_wdata <= banks;
    @(posedge clk_i);
    cfg_we <= 1'b0;
  endtask

  // Entries are {code_word, attr_word, y_word, x_word}.
  task automatic run_directed();
    send_entry({16'h0000, 16'h0000, 16'h0000, 16'h0000});
    send_entry({16'hffff, 16'hffff, 16'hfdff, 16'hfa00});
    send_entry({16'hffff, 16'hffff, 16'hffff, 16'hffff});
    send_entry({16'h1357, 16'h2468, 16'h0000, 16'h0400});
    send_entry({16'h3fff, 16'h0040, 16'h0200, 16'h01ff});
    send_entry({16'h4000, 16'h1095, 16'h2000, 16'h3800});
    send_entry({16'h8123, 16'h0fea, 16'h7800, 16'h0000});
    send_entry({16'hc000, 16'h8800, 16'hf3ff, 16'hf3ff});
    send_entry({16'h5555, 16'h5533, 16'h0e55, 16'h0a55});
    send_entry({16'haaaa, 16'haaaa, 16'haaaa, 16'haaaa});
    send_entry({16'h5555, 16'h5555, 16'h5555, 16'h5155});
    send_entry({16'hffff, 16'h0000, 16'hf000, 16'hf000});
    send_entry({16'h1234, 16'h30c0, 16'hf100, 16'h0080});
  endtask

  function automatic logic [63:0] random_entry(input logic hide);
    logic [63:0] e;
    e = {$urandom, $urandom};
    e[sere_pkg::HideBit] = hide;
    return e;
  endfunction

  initial begin
    int          phase;
    int          visible;
    logic        hide;
    logic [10:0] width, height;
    logic [15:0] banks;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed entries, first with the reset settings, then mirrored.
    run_directed();
    wait_idle();
    write_config(1'b1, 11'd0, 11'h7ff, 16'hffff);
    run_directed();
    wait_idle();

    for (phase = 0; phase < 5; phase++) begin
      width  = 11'($urandom);
      height = 11'($urandom);
      banks  = 16'($urandom);
      case (phase)
        0:       write_config(1'b1, 11'd1, 11'd1024, banks);
        1:       write_config(1'b0, 11'd1024, 11'd1, 16'h0000);
        2:       write_config(1'b1, 11'h7ff, 11'd0, banks);
        3:       write_config(1'($urandom_range(0, 1)), width, height, banks);
        default: write_config(1'b1, 11'd320, 11'd240, banks);
      endcase
      visible = 0;
      while (visible < 15) begin
        hide = ($urandom_range(0, 7) == 0);
        send_entry(random_entry(hide));
        if (!hide) visible++;
      end
      wait_idle();
    end

    if (fail_count == 0 && rows_pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("status: fail");
    $finish;
  end

endmodule
